[rtl/sign_magnitude_byte_alu_macros.svh]
// assertion macros for the sign-magnitude byte alu
// used by rtl/sign_magnitude_byte_alu.sv, no other dependencies
`ifndef SIGN_MAGNITUDE_BYTE_ALU_MACROS_SVH
`define SIGN_MAGNITUDE_BYTE_ALU_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define SMBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sign_magnitude_byte_alu: check failed");
// next-cycle implication, disabled while reset is low
`define SMBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sign_magnitude_byte_alu: check failed");
`else
`define SMBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SMBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/smba_pkg.sv]
// types, codes and step functions for the sign-magnitude byte alu
// no dependencies
package smba_pkg;

    localparam int MAG_W = 7;
    localparam int WORD_W = MAG_W + 1;
    localparam logic [WORD_W-1:0] SIGN_BIT = 8'h80;
    localparam logic [WORD_W-1:0] ONE_LSB = 8'h01;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    // payload carried between pipeline stages
    typedef struct packed {
        t_op              op;
        logic             sign;
        logic [MAG_W-1:0] ma;
        logic [MAG_W-1:0] mb;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] quo;
        logic [MAG_W-1:0] acc;
        logic [WORD_W-1:0] add_res;
    } t_stage;

    // sign-magnitude to two's complement, minus zero becomes zero
    function automatic logic [WORD_W-1:0] to_twos(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] m;
        m = {1'b0, x[MAG_W-1:0]};
        if (x[WORD_W-1]) begin
            return WORD_W'(~m + ONE_LSB);
        end
        return m;
    endfunction

    // two's complement to sign-magnitude
    function automatic logic [WORD_W-1:0] from_twos(input logic [WORD_W-1:0] r);
        if (r[WORD_W-1]) begin
            return WORD_W'((r ^ {1'b0, {MAG_W{1'b1}}}) + ONE_LSB);
        end
        return r;
    endfunction

    // sign-magnitude add, minus zero result folded to zero
    function automatic logic [WORD_W-1:0] add_sm(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = from_twos(WORD_W'(to_twos(a) + to_twos(b)));
        if (r == SIGN_BIT) begin
            r = '0;
        end
        return r;
    endfunction

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [WORD_W-1:0] div_step(input logic [MAG_W-1:0] rem,
                                                   input logic nbit,
                                                   input logic [MAG_W-1:0] mb);
        logic [WORD_W-1:0] sh;
        sh = {rem, nbit};
        if (sh >= {1'b0, mb}) begin
            return {1'b1, MAG_W'(sh - {1'b0, mb})};
        end
        return {1'b0, sh[MAG_W-1:0]};
    endfunction

    // one shift-and-add multiply step, kept modulo 128
    function automatic logic [MAG_W-1:0] mul_step(input logic [MAG_W-1:0] acc,
                                                  input logic [MAG_W-1:0] ma,
                                                  input logic bbit,
                                                  input logic [2:0] k);
        logic [MAG_W-1:0] pp;
        pp = MAG_W'(ma << k);
        if (bbit) begin
            return MAG_W'(acc + pp);
        end
        return acc;
    endfunction

endpackage

[rtl/sign_magnitude_byte_alu.sv]
// sign-magnitude byte alu: an accepted item passes stage 1, stage 2 and stage 3 to result valid,
// throughput one item per cycle when the output is not stalled
// three stages: add, high quotient and low product bits; middle bits; rest and select
// synchronous active-low reset clears the stage valid bits only, payload is not reset
// depends on smba_pkg and sign_magnitude_byte_alu_macros.svh
`include "sign_magnitude_byte_alu_macros.svh"

module sign_magnitude_byte_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_op,
    input  logic [smba_pkg::WORD_W-1:0]  i_operand_a,
    input  logic [smba_pkg::WORD_W-1:0]  i_operand_b,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [smba_pkg::WORD_W-1:0]  o_result_value,
    output logic                         o_divide_by_zero
);
    import smba_pkg::*;

    t_stage            r_s1, n_s1;
    t_stage            r_s2, n_s2;
    logic              r_v1, r_v2, r_v3;
    logic [WORD_W-1:0] r_result, n_result;
    logic              r_dz, n_dz;
    logic              ready1, ready2, ready3;

    // per-stage advance: a stage moves when empty or when the next one moves
    assign ready3  = !r_v3 || !i_stall;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_stall = !ready1;

    // stage 1: decode, add/subtract, quotient bits 6..4, product bits 0..2
    always_comb begin
        logic [WORD_W-1:0] bx;
        logic [WORD_W-1:0] step;
        n_s1.op   = t_op'(i_op);
        n_s1.sign = i_operand_a[WORD_W-1] ^ i_operand_b[WORD_W-1];
        n_s1.ma   = i_operand_a[MAG_W-1:0];
        n_s1.mb   = i_operand_b[MAG_W-1:0];
        bx = (n_s1.op == OP_SUB) ? (i_operand_b ^ SIGN_BIT) : i_operand_b;
        n_s1.add_res = add_sm(i_operand_a, bx);
        n_s1.rem = '0;
        n_s1.quo = '0;
        n_s1.acc = '0;
        for (int k = 6; k >= 4; k--) begin
            step = div_step(n_s1.rem, n_s1.ma[k], n_s1.mb);
            n_s1.quo[k] = step[WORD_W-1];
            n_s1.rem = step[MAG_W-1:0];
        end
        for (int k = 0; k <= 2; k++) begin
            n_s1.acc = mul_step(n_s1.acc, n_s1.ma, n_s1.mb[k], 3'(k));
        end
    end

    // stage 2: quotient bits 3..2, product bits 3..4
    always_comb begin
        logic [WORD_W-1:0] step;
        n_s2 = r_s1;
        for (int k = 3; k >= 2; k--) begin
            step = div_step(n_s2.rem, n_s2.ma[k], n_s2.mb);
            n_s2.quo[k] = step[WORD_W-1];
            n_s2.rem = step[MAG_W-1:0];
        end
        for (int k = 3; k <= 4; k++) begin
            n_s2.acc = mul_step(n_s2.acc, n_s2.ma, n_s2.mb[k], 3'(k));
        end
    end

    // stage 3: quotient bits 1..0, product bits 5..6, result select
    always_comb begin
        logic [WORD_W-1:0] step;
        logic [MAG_W-1:0]  rem;
        logic [MAG_W-1:0]  quo;
        logic [MAG_W-1:0]  acc;
        rem = r_s2.rem;
        quo = r_s2.quo;
        acc = r_s2.acc;
        for (int k = 1; k >= 0; k--) begin
            step = div_step(rem, r_s2.ma[k], r_s2.mb);
            quo[k] = step[WORD_W-1];
            rem = step[MAG_W-1:0];
        end
        for (int k = 5; k <= 6; k++) begin
            acc = mul_step(acc, r_s2.ma, r_s2.mb[k], 3'(k));
        end
        n_dz = 1'b0;
        unique case (r_s2.op)
            OP_ADD, OP_SUB: begin
                n_result = r_s2.add_res;
            end
            OP_MUL: begin
                n_result = {r_s2.sign, acc};
            end
            OP_DIV: begin
                if (r_s2.mb == '0) begin
                    n_dz     = 1'b1;
                    n_result = '0;
                end else begin
                    n_result = {r_s2.sign, quo};
                end
            end
            default: begin
                n_result = '0;
            end
        endcase
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_s1 <= n_s1;
        end
        if (ready2) begin
            r_s2 <= n_s2;
        end
        if (ready3) begin
            r_result <= n_result;
            r_dz     <= n_dz;
        end
    end

    assign o_valid          = r_v3;
    assign o_result_value   = r_result;
    assign o_divide_by_zero = r_dz;

    // checks
    `SMBA_ASSERT_IMPLY(a_dz_zero, i_clk, i_rst_n, r_v3 && r_dz, r_result == '0)
    `SMBA_ASSERT_IMPLY(a_no_minus_zero, i_clk, i_rst_n,
        r_v1 && (r_s1.op == OP_ADD || r_s1.op == OP_SUB), r_s1.add_res != SIGN_BIT)
    `SMBA_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, o_stall, r_v1 && r_v2 && r_v3 && i_stall)
    `SMBA_ASSERT_IMPLY(a_rem_bound, i_clk, i_rst_n,
        r_v1 && r_s1.op == OP_DIV && r_s1.mb != '0, r_s1.rem < r_s1.mb)
    `SMBA_ASSERT_NEXT(a_hold_full, i_clk, i_rst_n, r_v3 && i_stall && r_v2, r_v3 && r_v2)

endmodule
